// ----- design/fdoc_pkg.sv -----
// Shared types, codes and helpers for the fuzzy depth obstacle classifier.
// No dependencies; every other design file imports this package.
package fdoc_pkg;

  localparam int GRADE_BITS_DEF = 16;

  localparam int SCALE_NUM_W = 27;
  localparam int SCALE_DEN_W = 12;
  localparam int SCALE_Q_W   = 15;
  localparam int SCALE_STEP  = 3;
  localparam int FUZZ_Q_W    = 16;
  localparam int FUZZ_STEP   = 4;

  localparam logic [1:0] R_DEPTH_LOW  = 2'd0;
  localparam logic [1:0] R_DEPTH_MED  = 2'd1;
  localparam logic [1:0] R_SPREAD_LOW = 2'd2;
  localparam logic [1:0] R_SPREAD_MED = 2'd3;

  typedef logic [1:0] scale_mode_t;
  localparam scale_mode_t SC_LOW = 2'd0;
  localparam scale_mode_t SC_MID = 2'd1;
  localparam scale_mode_t SC_TOP = 2'd2;

  localparam logic [1:0] V_BLOCKED = 2'd0;
  localparam logic [1:0] V_CAUTION = 2'd1;
  localparam logic [1:0] V_CLEAR   = 2'd2;

  typedef struct packed {
    scale_mode_t             mode;
    logic [SCALE_NUM_W-1:0]  num;
    logic [SCALE_DEN_W-1:0]  den;
  } scale_op_t;

  // Prepares the division that maps one input onto the 16-bit scale.
  function automatic scale_op_t scale_prep(logic [11:0] x, logic [10:0] lo, logic [11:0] hi);
    scale_op_t  op;
    logic [11:0] dx;
    dx = x - {1'b0, lo};
    if (x < {1'b0, lo}) begin
      op.mode = SC_LOW;
      op.num  = {x, 15'd0};
      op.den  = {1'b0, lo};
    end else if (x < hi) begin
      op.mode = SC_MID;
      op.num  = {dx, 15'd0} - SCALE_NUM_W'(dx);
      op.den  = hi - {1'b0, lo};
    end else begin
      op.mode = SC_TOP;
      op.num  = '0;
      op.den  = SCALE_DEN_W'(1);
    end
    return op;
  endfunction

endpackage

// ----- design/fdoc_div.sv -----
// Pipelined restoring divider, STEP quotient bits per register stage.
// Uses fdoc_pkg; the quotient must be known to fit in QW bits.
module fdoc_div #(
  parameter int NW   = 27,
  parameter int DW   = 12,
  parameter int QW   = 15,
  parameter int STEP = 3,
  parameter int PW   = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [PW-1:0] side_i,
  output logic          valid_o,
  output logic [QW-1:0] quot_o,
  output logic [PW-1:0] side_o
);
  import fdoc_pkg::*;

  localparam int NSTG = QW / STEP;

  logic          valid_q [NSTG];
  logic [NW-1:0] rem_q   [NSTG];
  logic [DW-1:0] den_q   [NSTG];
  logic [QW-1:0] quot_q  [NSTG];
  logic [PW-1:0] side_q  [NSTG];

  for (genvar k = 0; k < NSTG; k++) begin : g_stg
    logic          valid_in;
    logic [NW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [QW-1:0] quot_in;
    logic [PW-1:0] side_in;
    logic [NW-1:0] rem_d;
    logic [QW-1:0] quot_d;

    if (k == 0) begin : g_first
      assign valid_in = valid_i;
      assign rem_in   = num_i;
      assign den_in   = den_i;
      assign quot_in  = '0;
      assign side_in  = side_i;
    end else begin : g_next
      assign valid_in = valid_q[k-1];
      assign rem_in   = rem_q[k-1];
      assign den_in   = den_q[k-1];
      assign quot_in  = quot_q[k-1];
      assign side_in  = side_q[k-1];
    end

    always_comb begin
      int          bitpos;
      logic [NW-1:0] sd;
      rem_d  = rem_in;
      quot_d = quot_in;
      for (int j = 0; j < STEP; j++) begin
        bitpos = QW - 1 - (k * STEP + j);
        sd = NW'(den_in) << bitpos;
        if (rem_d >= sd) begin
          rem_d = rem_d - sd;
          quot_d[bitpos] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= valid_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_d;
        den_q[k]  <= den_in;
        quot_q[k] <= quot_d;
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = valid_q[NSTG-1];
  assign quot_o  = quot_q[NSTG-1];
  assign side_o  = side_q[NSTG-1];

endmodule

// ----- design/fdoc_infer.sv -----
// Grading of both scaled inputs, the nine rules and the centroid sums.
// Uses fdoc_pkg for the scale mode codes; one register stage.
module fdoc_infer #(
  parameter int GB = fdoc_pkg::GRADE_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [14:0]                qa_i,
  input  fdoc_pkg::scale_mode_t      ma_i,
  input  logic [14:0]                qs_i,
  input  fdoc_pkg::scale_mode_t      ms_i,
  output logic                       valid_o,
  output logic [GB+17:0]             num_o,
  output logic [GB+1:0]              den_o,
  output logic                       zero_o
);
  import fdoc_pkg::*;

  localparam logic [GB-1:0] GMAX = {GB{1'b1}};

  function automatic logic [15:0] to_v(logic [14:0] q, scale_mode_t m);
    logic [15:0] v;
    case (m)
      SC_LOW:  v = {1'b0, q};
      SC_MID:  v = {1'b1, q};
      default: v = 16'hFFFF;
    endcase
    return v;
  endfunction

  // Slope of one set edge: n * GMAX / 16384, n at most 16384.
  function automatic logic [GB-1:0] ramp(logic [14:0] n);
    logic [GB+14:0] p;
    p = {n, {GB{1'b0}}} - (GB+15)'(n);
    return p[GB+13:14];
  endfunction

  function automatic logic [GB-1:0] g_low(logic [15:0] v);
    logic [15:0] t;
    logic [GB-1:0] g;
    t = 16'd32768 - v;
    if (v < 16'd16384) g = GMAX;
    else if (v < 16'd32768) g = ramp(t[14:0]);
    else g = '0;
    return g;
  endfunction

  function automatic logic [GB-1:0] g_med(logic [15:0] v);
    logic [15:0] up;
    logic [15:0] dn;
    logic [GB-1:0] g;
    up = v - 16'd16384;
    dn = 16'd49152 - v;
    if (v < 16'd16384) g = '0;
    else if (v < 16'd32768) g = ramp(up[14:0]);
    else if (v < 16'd49152) g = ramp(dn[14:0]);
    else g = '0;
    return g;
  endfunction

  function automatic logic [GB-1:0] g_high(logic [15:0] v);
    logic [15:0] up;
    logic [GB-1:0] g;
    up = v - 16'd32768;
    if (v < 16'd32768) g = '0;
    else if (v < 16'd49152) g = ramp(up[14:0]);
    else g = GMAX;
    return g;
  endfunction

  function automatic logic [GB-1:0] mn(logic [GB-1:0] a, logic [GB-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic [GB-1:0] mx(logic [GB-1:0] a, logic [GB-1:0] b);
    return (a > b) ? a : b;
  endfunction

  logic [15:0]   va, vs;
  logic [GB-1:0] a_l, a_m, a_h, s_l, s_m, s_h;
  logic [GB-1:0] e_l, e_m, e_h;
  logic [GB+17:0] num_d;
  logic [GB+1:0]  den_d;
  logic           valid_q;
  logic [GB+17:0] num_q;
  logic [GB+1:0]  den_q;
  logic           zero_q;

  always_comb begin
    va  = to_v(qa_i, ma_i);
    vs  = to_v(qs_i, ms_i);
    a_l = g_low(va);
    a_m = g_med(va);
    a_h = g_high(va);
    s_l = g_low(vs);
    s_m = g_med(vs);
    s_h = g_high(vs);
    e_l = mx(mx(mn(a_l, s_l), mn(a_l, s_m)), mx(mn(a_l, s_h), mn(a_m, s_h)));
    e_m = mx(mx(mn(a_m, s_l), mn(a_m, s_m)), mn(a_h, s_h));
    e_h = mx(mn(a_h, s_l), mn(a_h, s_m));
    // Centroids 8192, 32768 and 57344 = 65536 - 8192 as shifts.
    num_d = ((GB+18)'(e_l) << 13) + ((GB+18)'(e_m) << 15)
          + ((GB+18)'(e_h) << 16) - ((GB+18)'(e_h) << 13);
    den_d = (GB+2)'(e_l) + (GB+2)'(e_m) + (GB+2)'(e_h);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q  <= num_d;
      den_q  <= den_d;
      zero_q <= (den_d == '0);
    end
  end

  assign valid_o = valid_q;
  assign num_o   = num_q;
  assign den_o   = den_q;
  assign zero_o  = zero_q;

endmodule

// ----- design/fdoc_depth.sv -----
// Maps the defuzzified scale value back to centimetres and classifies it.
// Uses fdoc_pkg for verdict codes; two register stages, the second is the output.
module fdoc_depth (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  logic [15:0] s_i,
  input  logic        zero_i,
  input  logic [10:0] lo_i,
  input  logic [11:0] hi_i,
  output logic        valid_o,
  output logic [1:0]  verdict_o,
  output logic [11:0] eff_o,
  output logic [15:0] scaled_o
);
  import fdoc_pkg::*;

  localparam logic [2:0] DM_ZERO = 3'd0;
  localparam logic [2:0] DM_LOW  = 3'd1;
  localparam logic [2:0] DM_TOP  = 3'd2;
  localparam logic [2:0] DM_UP   = 3'd3;
  localparam logic [2:0] DM_DN   = 3'd4;

  logic [11:0] lo_x;
  logic [14:0] d;
  logic [2:0]  mode_d;
  logic [27:0] prod_d;

  logic        valid_a_q;
  logic [2:0]  mode_a_q;
  logic [27:0] prod_a_q;
  logic [15:0] s_a_q;

  logic [27:0] q0, r, qc;
  logic [11:0] e_d;
  logic [1:0]  verdict_d;

  logic        valid_q;
  logic [1:0]  verdict_q;
  logic [11:0] eff_q;
  logic [15:0] scaled_q;

  assign lo_x = {1'b0, lo_i};
  assign d    = s_i[14:0];

  always_comb begin
    if (zero_i) begin
      mode_d = DM_ZERO;
      prod_d = '0;
    end else if (!s_i[15]) begin
      mode_d = DM_LOW;
      prod_d = 28'(s_i[14:0]) * 28'(lo_i);
    end else if (s_i == 16'hFFFF) begin
      mode_d = DM_TOP;
      prod_d = '0;
    end else if (hi_i >= lo_x) begin
      mode_d = DM_UP;
      prod_d = 28'(d) * 28'(hi_i - lo_x);
    end else begin
      // Rounded up, so the downward mapping still floors the depth.
      mode_d = DM_DN;
      prod_d = 28'(d) * 28'(lo_x - hi_i) + 28'd32766;
    end
  end

  always_comb begin
    // Division by 32767: estimate, then one correction step.
    q0 = (prod_a_q + (prod_a_q >> 15)) >> 15;
    r  = prod_a_q - (q0 << 15) + q0;
    qc = (r >= 28'd32767) ? q0 + 28'd1 : q0;
    case (mode_a_q)
      DM_LOW:  e_d = prod_a_q[26:15];
      DM_TOP:  e_d = hi_i;
      DM_UP:   e_d = lo_x + qc[11:0];
      DM_DN:   e_d = lo_x - qc[11:0];
      default: e_d = '0;
    endcase
    if (mode_a_q == DM_ZERO) verdict_d = V_CLEAR;
    else if (e_d < lo_x) verdict_d = V_BLOCKED;
    else if (e_d < hi_i) verdict_d = V_CAUTION;
    else verdict_d = V_CLEAR;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_q   <= 1'b0;
    end else if (en_i) begin
      valid_a_q <= valid_i;
      valid_q   <= valid_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mode_a_q  <= mode_d;
      prod_a_q  <= prod_d;
      s_a_q     <= zero_i ? 16'd0 : s_i;
      verdict_q <= verdict_d;
      eff_q     <= e_d;
      scaled_q  <= s_a_q;
    end
  end

  assign valid_o   = valid_q;
  assign verdict_o = verdict_q;
  assign eff_o     = eff_q;
  assign scaled_o  = scaled_q;

endmodule

// ----- design/fuzzy_depth_obstacle_classifier_unit.sv -----
// Fuzzy obstacle classifier: one region word in, one verdict word out, one word per
// cycle sustained. Its stages: the input stage, five stages of the scaling dividers,
// the inference stage, four stages of the centroid divider and two output mapping
// stages. The whole pipeline advances together and holds while the
// output word is stalled. Thresholds are read live by several stages, so write them
// only when the pipeline holds no word.
module fuzzy_depth_obstacle_classifier_unit #(
  parameter int GRADE_BITS = fdoc_pkg::GRADE_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [11:0] avg_depth_i,
  input  logic [11:0] depth_spread_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  verdict_o,
  output logic [11:0] effective_depth_o,
  output logic [15:0] scaled_effective_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [11:0] cfg_data_i
);
  import fdoc_pkg::*;

  logic [10:0] depth_low_q, spread_low_q;
  logic [11:0] depth_med_q, spread_med_q;

  logic      en;
  logic      valid_s1_q;
  scale_op_t opa_q, ops_q;

  logic              va_div, vs_div;
  logic [14:0]       qa, qs;
  scale_mode_t       ma, ms;
  logic              v_inf;
  logic [GRADE_BITS+17:0] num;
  logic [GRADE_BITS+1:0]  den;
  logic              zero;
  logic              v_fz;
  logic [15:0]       s_val;
  logic              zero_fz;

  assign en          = !(out_valid_o && out_stall_i);
  assign in_stall_o  = !en;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_low_q  <= 11'd75;
      depth_med_q  <= 12'd150;
      spread_low_q <= 11'd15;
      spread_med_q <= 12'd30;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        R_DEPTH_LOW:  depth_low_q  <= cfg_data_i[10:0];
        R_DEPTH_MED:  depth_med_q  <= cfg_data_i;
        R_SPREAD_LOW: spread_low_q <= cfg_data_i[10:0];
        R_SPREAD_MED: spread_med_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_s1_q <= 1'b0;
    end else if (en) begin
      valid_s1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      opa_q <= scale_prep(avg_depth_i, depth_low_q, depth_med_q);
      ops_q <= scale_prep(depth_spread_i, spread_low_q, spread_med_q);
    end
  end

  fdoc_div #(
    .NW(SCALE_NUM_W), .DW(SCALE_DEN_W), .QW(SCALE_Q_W), .STEP(SCALE_STEP), .PW(2)
  ) u_div_a (
    .clk_i, .rst_ni, .en_i(en), .valid_i(valid_s1_q),
    .num_i(opa_q.num), .den_i(opa_q.den), .side_i(opa_q.mode),
    .valid_o(va_div), .quot_o(qa), .side_o(ma)
  );

  fdoc_div #(
    .NW(SCALE_NUM_W), .DW(SCALE_DEN_W), .QW(SCALE_Q_W), .STEP(SCALE_STEP), .PW(2)
  ) u_div_s (
    .clk_i, .rst_ni, .en_i(en), .valid_i(valid_s1_q),
    .num_i(ops_q.num), .den_i(ops_q.den), .side_i(ops_q.mode),
    .valid_o(vs_div), .quot_o(qs), .side_o(ms)
  );

  fdoc_infer #(.GB(GRADE_BITS)) u_infer (
    .clk_i, .rst_ni, .en_i(en), .valid_i(va_div && vs_div),
    .qa_i(qa), .ma_i(ma), .qs_i(qs), .ms_i(ms),
    .valid_o(v_inf), .num_o(num), .den_o(den), .zero_o(zero)
  );

  fdoc_div #(
    .NW(GRADE_BITS + 18), .DW(GRADE_BITS + 2), .QW(FUZZ_Q_W), .STEP(FUZZ_STEP), .PW(1)
  ) u_div_f (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v_inf),
    .num_i(num), .den_i(den), .side_i(zero),
    .valid_o(v_fz), .quot_o(s_val), .side_o(zero_fz)
  );

  fdoc_depth u_depth (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v_fz),
    .s_i(s_val), .zero_i(zero_fz), .lo_i(depth_low_q), .hi_i(depth_med_q),
    .valid_o(out_valid_o), .verdict_o(verdict_o),
    .eff_o(effective_depth_o), .scaled_o(scaled_effective_o)
  );

endmodule

// ----- design/fdoc_checker.sv -----
// Port-level checks for the fuzzy depth obstacle classifier, bound to the top level.
// Uses fdoc_pkg for the verdict codes.
module fdoc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  verdict_o,
  input logic [11:0] effective_depth_o,
  input logic [15:0] scaled_effective_o
);
  import fdoc_pkg::*;

  // A stalled output word holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(verdict_o)
      && $stable(effective_depth_o) && $stable(scaled_effective_o))
    else $error("stalled output word changed");

  // Back pressure only comes from a full, stalled output.
  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back pressure");

  a_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> verdict_o == V_BLOCKED || verdict_o == V_CAUTION
      || verdict_o == V_CLEAR)
    else $error("verdict code out of range");

  // The centroid average lies between the outer set centroids.
  a_scaled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> scaled_effective_o >= 16'd8192 && scaled_effective_o <= 16'd57344)
    else $error("defuzzified value outside centroid range");

endmodule

bind fuzzy_depth_obstacle_classifier_unit fdoc_checker u_fdoc_checker (
  .clk_i, .rst_ni, .in_stall_o, .out_valid_o, .out_stall_i,
  .verdict_o, .effective_depth_o, .scaled_effective_o
);
